[design/plu_pkg.sv]
`timescale 1ns / 1ps
// plu_pkg: shared types and constants for the positional list unit.
// No dependencies.
package plu_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int WORD_W       = 32;
  localparam int POS_W        = 8;
  localparam int CMD_W        = 3;
  localparam int STAT_W       = 2;
  localparam int ECNT_W       = 5;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD  = 3'd0,
    CMD_INS_TAIL  = 3'd1,
    CMD_INS_AFTER = 3'd2,
    CMD_DEL_HEAD  = 3'd3,
    CMD_DEL_TAIL  = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_DUMP      = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_t;

  // Per-cycle operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] idx;  // insert/delete slot, or last occupied slot on rotate
  } ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

endpackage

[design/plu_cell.sv]
`timescale 1ns / 1ps
// plu_cell: one storage slot of the list chain; shifts, loads, rotates or holds.
// Depends on plu_pkg.
module plu_cell #(
  parameter int INDEX = 0
) (
  input  logic           clk,
  input  plu_pkg::ctl_t  ctl,
  input  plu_pkg::word_t value,
  input  plu_pkg::word_t left,
  input  plu_pkg::word_t right,
  input  plu_pkg::word_t wrap,
  output plu_pkg::word_t data
);
  import plu_pkg::*;

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

  word_t data_next;

  always_comb begin
    data_next = data;
    unique case (ctl.op)
      OP_INS: begin
        if (MY_IDX > ctl.idx) begin
          data_next = left;
        end else if (MY_IDX == ctl.idx) begin
          data_next = value;
        end
      end
      OP_DEL: begin
        if (MY_IDX >= ctl.idx) begin
          data_next = right;
        end
      end
      OP_ROT: begin
        if (MY_IDX < ctl.idx) begin
          data_next = right;
        end else if (MY_IDX == ctl.idx) begin
          data_next = wrap;
        end
      end
      OP_HOLD: data_next = data;
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[design/plu_ctrl.sv]
`timescale 1ns / 1ps
// plu_ctrl: command decode, entry count, dump sequencer and output register.
// Depends on plu_pkg; drives the cell chain through ctl_t.
module plu_ctrl #(
  parameter int CAPACITY = plu_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [plu_pkg::CMD_W-1:0]      command,
  input  logic [plu_pkg::POS_W-1:0]      position,
  output logic                           out_valid,
  input  logic                           out_ready,
  output plu_pkg::word_t                 entry_value,
  output logic                           is_last,
  output logic [plu_pkg::STAT_W-1:0]     status,
  output logic [plu_pkg::ECNT_W-1:0]     entry_count,
  input  plu_pkg::word_t                 head,
  output plu_pkg::ctl_t                  ctl
);
  import plu_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] dump_idx, dump_idx_next;

  cmd_t             cmd;
  logic             in_fire, out_free, out_load, dump_last, full, empty;
  logic [CMP_W-1:0] pos_ext, cnt_ext;
  word_t            value_next;
  logic             last_next;
  stat_t            status_next;

  assign cmd       = cmd_t'(command);
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign full      = (count == CNT_FULL);
  assign empty     = (count == '0);
  assign pos_ext   = CMP_W'(position);
  assign cnt_ext   = CMP_W'(count);
  assign dump_last = (dump_idx == count - CNT_ONE);

  always_comb begin
    state_next    = state;
    count_next    = count;
    dump_idx_next = dump_idx;
    ctl           = '{op: OP_HOLD, idx: '0};
    out_load      = 1'b0;
    value_next    = '0;
    last_next     = 1'b1;
    status_next   = STAT_OK;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          out_load = 1'b1;
          unique case (cmd)
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AFTER: begin
              if (full) begin
                status_next = STAT_FULL;
              end else begin
                ctl.op     = OP_INS;
                count_next = count + CNT_ONE;
                priority if (cmd == CMD_INS_HEAD) begin
                  ctl.idx = '0;
                end else if (cmd == CMD_INS_TAIL || pos_ext >= cnt_ext) begin
                  ctl.idx = POS_W'(count);
                end else begin
                  ctl.idx = position + POS_W'(1);
                end
              end
            end
            CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS: begin
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                ctl.op     = OP_DEL;
                count_next = count - CNT_ONE;
                priority if (cmd == CMD_DEL_HEAD) begin
                  ctl.idx = '0;
                end else if (cmd == CMD_DEL_TAIL || pos_ext > cnt_ext) begin
                  ctl.idx = POS_W'(count - CNT_ONE);
                end else if (position == '0) begin
                  ctl.idx = '0;
                end else begin
                  ctl.idx = position - POS_W'(1);
                end
              end
            end
            CMD_DUMP: begin
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                out_load      = 1'b0;
                state_next    = ST_DUMP;
                dump_idx_next = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          // head goes out, chain rotates left over the occupied slots
          out_load      = 1'b1;
          value_next    = head;
          last_next     = dump_last;
          ctl.op        = OP_ROT;
          ctl.idx       = POS_W'(count - CNT_ONE);
          dump_idx_next = dump_idx + CNT_ONE;
          if (dump_last) begin
            state_next    = ST_IDLE;
            dump_idx_next = '0;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      dump_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dump_idx <= dump_idx_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      entry_value <= value_next;
      is_last     <= last_next;
      status      <= status_next;
      entry_count <= ECNT_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("entry count above capacity");

  a_mid_beat_in_dump: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_last) |-> (state == ST_DUMP))
    else $error("non-final beat pending outside a dump");

  a_count_frozen_dump: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |=> (count == $past(count)))
    else $error("entry count changed during dump");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !full &&
     (cmd == CMD_INS_HEAD || cmd == CMD_INS_TAIL || cmd == CMD_INS_AFTER))
    |=> (count == $past(count) + CNT_ONE))
    else $error("insert did not add one entry");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !empty &&
     (cmd == CMD_DEL_HEAD || cmd == CMD_DEL_TAIL || cmd == CMD_DEL_POS))
    |=> (count == $past(count) - CNT_ONE))
    else $error("delete did not remove one entry");

endmodule

[design/positional_list_insert_delete_unit.sv]
`timescale 1ns / 1ps
// positional_list_insert_delete_unit: bounded ordered list of signed words.
// Depends on plu_pkg, plu_cell, plu_ctrl.
//
// The list lives in a chain of CAPACITY cells, head in cell 0. Every insert or
// delete is one beat in and one beat out: all cells shift toward or away from
// the edited slot in parallel, so edits are accepted every cycle while the
// output register drains. A dump of n entries answers with n beats, one per
// cycle while the receiver is ready, by rotating the occupied cells past the
// head; the input stalls after the dump beat is taken until the last entry
// beat is loaded. A dump of an empty list gives one beat with status empty.
// entry_count carries the low five bits of the count.
module positional_list_insert_delete_unit #(
  parameter int CAPACITY = plu_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [plu_pkg::CMD_W-1:0]   command,
  input  plu_pkg::word_t              value,
  input  logic [plu_pkg::POS_W-1:0]   position,
  output logic                        out_valid,
  input  logic                        out_ready,
  output plu_pkg::word_t              entry_value,
  output logic                        is_last,
  output logic [plu_pkg::STAT_W-1:0]  status,
  output logic [plu_pkg::ECNT_W-1:0]  entry_count
);
  import plu_pkg::*;

  ctl_t  ctl;
  word_t cell_data  [CAPACITY];
  word_t left_data  [CAPACITY];
  word_t right_data [CAPACITY];

  plu_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .position   (position),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .entry_value(entry_value),
    .is_last    (is_last),
    .status     (status),
    .entry_count(entry_count),
    .head       (cell_data[0]),
    .ctl        (ctl)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_data[i] = '0;
    end else begin : g_inner_l
      assign left_data[i] = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data[i] = '0;
    end else begin : g_inner_r
      assign right_data[i] = cell_data[i+1];
    end

    plu_cell #(
      .INDEX(i)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .value(value),
      .left (left_data[i]),
      .right(right_data[i]),
      .wrap (cell_data[0]),
      .data (cell_data[i])
    );
  end

endmodule

[bench/tb_positional_list_insert_delete_unit.sv]
`timescale 1ns / 1ps
// tb_positional_list_insert_delete_unit: self-checking bench for the positional list unit.
// Depends on plu_pkg and positional_list_insert_delete_unit; a queue-based predictor
// tracks the list and every output beat is compared against it in order.
module tb_positional_list_insert_delete_unit;
  import plu_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int CAP            = CAPACITY_DEF;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 2 * CAP + 8;
  localparam int HOLD_CYCLES    = 60;
  localparam int RAND_PER_PHASE = 30;

  typedef struct {
    word_t              v;
    logic               last;
    logic [STAT_W-1:0]  st;
    logic [ECNT_W-1:0]  cnt;
  } beat_t;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    word_t              v;
    logic [POS_W-1:0]   pos;
    int                 reps;
    bit                 typed;
    word_t              ev;
    logic [STAT_W-1:0]  est;
    logic [ECNT_W-1:0]  ecnt;
  } row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [CMD_W-1:0]   command;
  word_t              value;
  logic [POS_W-1:0]   position;
  logic               out_valid;
  logic               out_ready;
  word_t              entry_value;
  logic               is_last;
  logic [STAT_W-1:0]  status;
  logic [ECNT_W-1:0]  entry_count;

  word_t  list_words[$];
  beat_t  pending_beats[$];
  row_t   dir_rows[$];

  int errors       = 0;
  int beats_seen   = 0;
  int cmds_sent    = 0;
  int full_hits    = 0;
  int empty_hits   = 0;
  int dumps_sent   = 0;
  int cycles       = 0;
  int send_idle_pct = 9;
  int recv_idle_pct = 76;
  int holds_asked  = 0;
  int holds_served = 0;

  positional_list_insert_delete_unit #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .value(value), .position(position),
    .out_valid(out_valid), .out_ready(out_ready),
    .entry_value(entry_value), .is_last(is_last),
    .status(status), .entry_count(entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    errors++;
  endtask

  // Updates the list copy and queues the beats this command should produce.
  task automatic apply_command(input logic [CMD_W-1:0] c, input word_t v,
                               input logic [POS_W-1:0] p, input bit record);
    int    n;
    int    idx;
    beat_t b;
    n = list_words.size();
    b.v = '0;
    b.last = 1'b1;
    b.st = STAT_OK;
    idx = 0;
    case (c)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AFTER: begin
        if (n >= CAP) begin
          b.st = STAT_FULL;
          full_hits++;
        end else begin
          if (c == CMD_INS_HEAD) idx = 0;
          else if (c == CMD_INS_TAIL || p >= n) idx = n;
          else idx = p + 1;
          list_words.insert(idx, v);
        end
      end
      CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS: begin
        if (n == 0) begin
          b.st = STAT_EMPTY;
          empty_hits++;
        end else begin
          if (c == CMD_DEL_HEAD) idx = 0;
          else if (c == CMD_DEL_TAIL || p > n) idx = n - 1;
          else idx = (p == 0) ? 0 : p - 1;
          list_words.delete(idx);
        end
      end
      CMD_DUMP: begin
        dumps_sent++;
        if (n == 0) begin
          b.st = STAT_EMPTY;
          empty_hits++;
        end
      end
      default: ;
    endcase
    b.cnt = ECNT_W'(list_words.size());
    if (record) begin
      if (c == CMD_DUMP && n != 0) begin
        for (int i = 0; i < n; i++) begin
          b.v = list_words[i];
          b.last = (i == n - 1);
          pending_beats.push_back(b);
        end
      end else begin
        pending_beats.push_back(b);
      end
    end
  endtask

  // Called at or after a rising edge; returns at the edge where the beat is taken.
  task automatic send_beat(input logic [CMD_W-1:0] c, input word_t v,
                           input logic [POS_W-1:0] p);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    command  = c;
    value    = v;
    position = p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cmds_sent++;
  endtask

  task automatic row(input logic [CMD_W-1:0] c, input word_t v, input logic [POS_W-1:0] p,
                     input int reps, input bit typed, input word_t ev,
                     input logic [STAT_W-1:0] est, input logic [ECNT_W-1:0] ecnt);
    row_t r;
    r.cmd = c;
    r.v = v;
    r.pos = p;
    r.reps = reps;
    r.typed = typed;
    r.ev = ev;
    r.est = est;
    r.ecnt = ecnt;
    dir_rows.push_back(r);
  endtask

  // Receiver: random ready, plus long hold-offs on request.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (holds_served < holds_asked) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_served++;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    beat_t b;
    if (!rst && out_valid && out_ready) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat value=%0d last=%0b status=%0d count=%0d",
                                  entry_value, is_last, status, entry_count));
      end else begin
        b = pending_beats.pop_front();
        if (entry_value !== b.v)
          report_mismatch($sformatf("entry_value %0d, want %0d", entry_value, b.v));
        if (is_last !== b.last)
          report_mismatch($sformatf("is_last %0b, want %0b", is_last, b.last));
        if (status !== b.st)
          report_mismatch($sformatf("status %0d, want %0d", status, b.st));
        if (entry_count !== b.cnt)
          report_mismatch($sformatf("entry_count %0d, want %0d", entry_count, b.cnt));
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d beats still pending", cycles,
             pending_beats.size());
    $display("tb_positional_list_insert_delete_unit: done, errors");
    $finish;
  end

  initial begin : stimulus
    row_t             r;
    logic [CMD_W-1:0] c;
    word_t            v;
    logic [POS_W-1:0] p;
    int               sel;
    int               directed;
    bit               grow;

    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_INS_HEAD;
    value = '0;
    position = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    row(CMD_DUMP,      32'sd0,        8'd0,   1, 1'b1, 32'sd0, STAT_EMPTY, 5'd0);
    row(CMD_DEL_HEAD,  32'sd0,        8'd0,   1, 1'b1, 32'sd0, STAT_EMPTY, 5'd0);
    row(CMD_DEL_TAIL,  32'sd0,        8'd0,   1, 1'b1, 32'sd0, STAT_EMPTY, 5'd0);
    row(CMD_DEL_POS,   32'sd0,        8'd255, 1, 1'b1, 32'sd0, STAT_EMPTY, 5'd0);
    row(CMD_INS_AFTER, 32'h7fffffff,  8'd0,   1, 1'b1, 32'sd0, STAT_OK,    5'd1);
    row(CMD_DEL_TAIL,  32'sd0,        8'd0,   1, 1'b1, 32'sd0, STAT_OK,    5'd0);
    row(CMD_INS_HEAD,  32'h80000000,  8'd0,   1, 1'b1, 32'sd0, STAT_OK,    5'd1);
    row(CMD_INS_TAIL,  -32'sd1,       8'd0,   1, 1'b1, 32'sd0, STAT_OK,    5'd2);
    row(CMD_INS_AFTER, 32'h55555555,  8'd0,   1, 1'b0, 32'sd0, STAT_OK,    5'd0);
    row(CMD_INS_AFTER, 32'haaaaaaaa,  8'd255, 1, 1'b0, 32'sd0, STAT_OK,    5'd0);
    row(CMD_DUMP,      32'sd0,        8'd0,   1, 1'b0, 32'sd0, STAT_OK,    5'd0);
    row(CMD_DEL_POS,   32'sd0,        8'd0,   1, 1'b0, 32'sd0, STAT_OK,    5'd0);
    row(CMD_DEL_POS,   32'sd0,        8'd1,   1, 1'b0, 32'sd0, STAT_OK,    5'd0);
    row(CMD_DEL_POS,   32'sd0,        8'd255, 1, 1'b0, 32'sd0, STAT_OK,    5'd0);
    row(CMD_UNUSED,    -32'sd1,       8'd255, 1, 1'b1, 32'sd0, STAT_OK,    5'd1);
    row(CMD_INS_TAIL,  32'sd1000,     8'd0,   CAP - 1, 1'b0, 32'sd0, STAT_OK, 5'd0);
    row(CMD_INS_HEAD,  32'sd7,        8'd0,   1, 1'b1, 32'sd0, STAT_FULL,  ECNT_W'(CAP));
    row(CMD_INS_AFTER, 32'sd7,        8'd3,   1, 1'b1, 32'sd0, STAT_FULL,  ECNT_W'(CAP));
    row(CMD_INS_TAIL,  32'sd7,        8'd0,   1, 1'b1, 32'sd0, STAT_FULL,  ECNT_W'(CAP));
    row(CMD_DUMP,      32'sd0,        8'd0,   1, 1'b0, 32'sd0, STAT_OK,    5'd0);
    row(CMD_DEL_POS,   32'sd0,        POS_W'(CAP), 1, 1'b0, 32'sd0, STAT_OK, 5'd0);
    row(CMD_DEL_POS,   32'sd0,        POS_W'(CAP + 1), 1, 1'b0, 32'sd0, STAT_OK, 5'd0);
    row(CMD_DEL_POS,   32'sd0,        8'd2,   1, 1'b0, 32'sd0, STAT_OK,    5'd0);
    row(CMD_INS_AFTER, 32'sd0,        8'd5,   1, 1'b0, 32'sd0, STAT_OK,    5'd0);
    row(CMD_DUMP,      32'sd0,        8'd0,   1, 1'b0, 32'sd0, STAT_OK,    5'd0);

    foreach (dir_rows[k]) begin
      r = dir_rows[k];
      for (int j = 0; j < r.reps; j++) begin
        send_beat(r.cmd, r.v + j, r.pos);
        apply_command(r.cmd, r.v + j, r.pos, !r.typed);
        if (r.typed) pending_beats.push_back('{r.ev, 1'b1, r.est, r.ecnt});
      end
    end
    directed = cmds_sent;

    grow = 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 9;  recv_idle_pct = 76; end
        1: begin send_idle_pct = 76; recv_idle_pct = 9;  end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          holds_asked++;   // long receiver stall while the sender keeps pushing
        end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (list_words.size() == CAP) grow = 1'b0;
        else if (list_words.size() == 0) grow = 1'b1;
        else if ($urandom_range(99) < 5) grow = !grow;
        sel = $urandom_range(99);
        if (sel < 3) c = CMD_UNUSED;
        else if (sel < 13) c = CMD_DUMP;
        else if ((sel < 80) == grow) c = CMD_W'($urandom_range(2));
        else c = CMD_W'(int'(CMD_DEL_HEAD) + $urandom_range(2));
        if ($urandom_range(4) == 0) p = POS_W'($urandom_range(255));
        else p = POS_W'($urandom_range(list_words.size() + 1));
        if ($urandom_range(6) == 0) begin
          case ($urandom_range(3))
            0: v = 32'h80000000;
            1: v = 32'h7fffffff;
            2: v = -32'sd1;
            default: v = 32'sd0;
          endcase
        end else begin
          v = word_t'($urandom);
        end
        send_beat(c, v, p);
        apply_command(c, v, p, 1'b1);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands (%0d directed, %0d dumps), %0d result beats checked",
             cmds_sent, directed, dumps_sent, beats_seen);
    $display("list-full refusals: %0d, empty-list outcomes: %0d, cycles: %0d",
             full_hits, empty_hits, cycles);
    if (errors == 0) begin
      $display("tb_positional_list_insert_delete_unit: done, clean");
    end else begin
      $display("tb_positional_list_insert_delete_unit: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
design/plu_pkg.sv
design/plu_cell.sv
design/plu_ctrl.sv
design/positional_list_insert_delete_unit.sv
bench/tb_positional_list_insert_delete_unit.sv
